/* design/hdlf_pkg.sv */
`default_nettype none

package hdlf_pkg;

  // Default sample width and fixed result width
  localparam int SampleWidthDef = 32;
  localparam int FluxW          = 32;

  // Stencil geometry
  localparam int NRows     = 5;
  localparam int NCols     = 5;
  localparam int FillW     = 3;
  localparam logic [FillW-1:0] FillFull = FillW'(NCols);

  // Laplacian queue between front and back
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // Five saturated Laplacians around the centre point
  typedef struct packed {
    logic signed [FluxW-1:0] south;
    logic signed [FluxW-1:0] north;
    logic signed [FluxW-1:0] east;
    logic signed [FluxW-1:0] west;
    logic signed [FluxW-1:0] centre;
  } lap_set_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

/* design/hdiff_laplacian_flux.sv */
// Horizontal-diffusion Laplacian flux stencil. Each input transfer carries one grid column
// (rows 0..4); a five-column sliding window forms five saturated Laplacians around the centre
// point and emits west, east, north and south fluxes (32-bit wrap). tuser marks the first
// column of a row; the first four columns of a row give no output. One column is taken every
// cycle while the Laplacian queue has room. The window register loads at the input transfer,
// the Laplacians then enter the queue and the flux output register loads from the queue. A
// two-entry Laplacian queue plus the output register absorb downstream stalls.
`default_nettype none

module hdiff_laplacian_flux #(
  parameter int SAMPLE_WIDTH = hdlf_pkg::SampleWidthDef
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   s_axis_tvalid,
  output logic                                        s_axis_tready,
  // sample_row0, sample_row1, sample_row2, sample_row3, sample_row4, zero pad
  input  wire logic [((hdlf_pkg::NRows*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // row_start
  input  wire logic                                   s_axis_tuser,
  output logic                                        m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  // flux_west, flux_east, flux_north, flux_south
  output logic [4*hdlf_pkg::FluxW-1:0]                m_axis_tdata
);

  localparam int SampW = hdlf_pkg::NRows * SAMPLE_WIDTH;

  logic               push, pop;
  hdlf_pkg::lap_set_t push_data, pop_data;
  hdlf_pkg::q_stat_t  q_stat;

  hdlf_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_samples_i   (s_axis_tdata[SampW-1:0]),
    .in_row_start_i (s_axis_tuser),
    .q_stat_i       (q_stat),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  hdlf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  hdlf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("push into full Laplacian queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("pop from empty Laplacian queue");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> q_stat.full)
    else $error("input stalled while queue has room");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_stat.empty && !m_axis_tvalid) |=> m_axis_tvalid)
    else $error("queued result not moved to output register");
`endif

endmodule

`default_nettype wire

/* design/hdlf_front.sv */
`default_nettype none

module hdlf_front #(
  parameter int SAMPLE_WIDTH = hdlf_pkg::SampleWidthDef
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [hdlf_pkg::NRows*SAMPLE_WIDTH-1:0] in_samples_i,
  input  wire logic                                 in_row_start_i,
  input  wire hdlf_pkg::q_stat_t                    q_stat_i,
  output logic                                      push_o,
  output hdlf_pkg::lap_set_t                        push_data_o
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int LapW = (SW + 3 > hdlf_pkg::FluxW + 1) ? SW + 3 : hdlf_pkg::FluxW + 1;
  localparam int FW   = hdlf_pkg::FluxW;

  logic signed [SW-1:0] win_q [hdlf_pkg::NRows][hdlf_pkg::NCols];
  logic [hdlf_pkg::FillW-1:0] fill_q, fill_d;
  logic res_valid_q, res_valid_d;
  logic accept;

  function automatic logic signed [LapW-1:0] sx(input logic signed [SW-1:0] v);
    sx = {{(LapW-SW){v[SW-1]}}, v};
  endfunction

  function automatic logic signed [FW-1:0] lap5(
    input logic signed [SW-1:0] c,
    input logic signed [SW-1:0] n,
    input logic signed [SW-1:0] s,
    input logic signed [SW-1:0] w,
    input logic signed [SW-1:0] e
  );
    logic signed [LapW-1:0] raw;
    logic [LapW-FW:0] top;
    raw = (sx(c) <<< 2) - sx(n) - sx(s) - sx(w) - sx(e);
    top = raw[LapW-1:FW-1];
    if ((&top) || !(|top)) begin
      lap5 = raw[FW-1:0];
    end else if (raw[LapW-1]) begin
      lap5 = {1'b1, {(FW-1){1'b0}}};
    end else begin
      lap5 = {1'b0, {(FW-1){1'b1}}};
    end
  endfunction

  // Window may advance once its pending result has gone into the queue
  assign in_ready_o = !res_valid_q || !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = res_valid_q && !q_stat_i.full;

  always_comb begin
    fill_d = fill_q;
    if (in_row_start_i) begin
      fill_d = hdlf_pkg::FillW'(1);
    end else if (fill_q != hdlf_pkg::FillFull) begin
      fill_d = fill_q + hdlf_pkg::FillW'(1);
    end
  end

  always_comb begin
    res_valid_d = res_valid_q && q_stat_i.full;
    if (accept) begin
      res_valid_d = (fill_d == hdlf_pkg::FillFull);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (accept) begin
        fill_q <= fill_d;
      end
    end
  end

  // Column window, oldest column at index 0
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int r = 0; r < hdlf_pkg::NRows; r++) begin
        for (int k = 0; k < hdlf_pkg::NCols - 1; k++) begin
          win_q[r][k] <= in_row_start_i ? '0 : win_q[r][k+1];
        end
        win_q[r][hdlf_pkg::NCols-1] <= in_samples_i[r*SW +: SW];
      end
    end
  end

  always_comb begin
    push_data_o.centre = lap5(win_q[2][2], win_q[1][2], win_q[3][2], win_q[2][1], win_q[2][3]);
    push_data_o.west   = lap5(win_q[2][1], win_q[1][1], win_q[3][1], win_q[2][0], win_q[2][2]);
    push_data_o.east   = lap5(win_q[2][3], win_q[1][3], win_q[3][3], win_q[2][2], win_q[2][4]);
    push_data_o.north  = lap5(win_q[1][2], win_q[0][2], win_q[2][2], win_q[1][1], win_q[1][3]);
    push_data_o.south  = lap5(win_q[3][2], win_q[2][2], win_q[4][2], win_q[3][1], win_q[3][3]);
  end

endmodule

`default_nettype wire

/* design/hdlf_queue.sv */
`default_nettype none

module hdlf_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire hdlf_pkg::lap_set_t push_data_i,
  input  wire logic               pop_i,
  output hdlf_pkg::lap_set_t      pop_data_o,
  output hdlf_pkg::q_stat_t       stat_o
);

  hdlf_pkg::lap_set_t mem_q [hdlf_pkg::QueueDepth];
  logic [hdlf_pkg::QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [hdlf_pkg::QueueCntW-1:0] count_q;

  assign stat_o.full  = (count_q == hdlf_pkg::QueueCntW'(hdlf_pkg::QueueDepth));
  assign stat_o.empty = (count_q == '0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + hdlf_pkg::QueuePtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + hdlf_pkg::QueuePtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + hdlf_pkg::QueueCntW'(1);
        2'b01:   count_q <= count_q - hdlf_pkg::QueueCntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/hdlf_back.sv */
`default_nettype none

module hdlf_back (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire hdlf_pkg::q_stat_t                q_stat_i,
  input  wire hdlf_pkg::lap_set_t               pop_data_i,
  output logic                                  pop_o,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [4*hdlf_pkg::FluxW-1:0]          out_data_o
);

  localparam int FW = hdlf_pkg::FluxW;

  logic            out_valid_q;
  logic [FW-1:0]   west_q, east_q, north_q, south_q;

  // Output register refills in the same cycle its transfer completes
  assign pop_o       = !q_stat_i.empty && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = {south_q, north_q, east_q, west_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      west_q  <= pop_data_i.centre - pop_data_i.west;
      east_q  <= pop_data_i.east   - pop_data_i.centre;
      north_q <= pop_data_i.centre - pop_data_i.north;
      south_q <= pop_data_i.south  - pop_data_i.centre;
    end
  end

endmodule

`default_nettype wire

/* dv/tb.sv */
`default_nettype none

module tb;

  localparam int NR = hdlf_pkg::NRows;
  localparam int FW = hdlf_pkg::FluxW;
  localparam int DW = ((NR * 32 + 7) / 8) * 8;
  localparam int HoldCycles = 300;
  localparam logic [31:0] SmpMax = 32'h7fff_ffff;
  localparam logic [31:0] SmpMin = 32'h8000_0000;

  typedef struct packed {
    logic          row_start;
    logic [DW-1:0] smp;  // row 0 in the low bits
  } column_t;

  // same layout as m_axis_tdata: west lowest
  typedef struct packed {
    logic [FW-1:0] south;
    logic [FW-1:0] north;
    logic [FW-1:0] east;
    logic [FW-1:0] west;
  } flux_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [DW-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [4*FW-1:0] m_axis_tdata;

  hdiff_laplacian_flux dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  column_t columns_pending[$];
  flux_t   flux_due[$];
  int      errors = 0;
  bit      src_gaps_on = 1'b1;
  bit      snk_gaps_on = 1'b1;
  int      hold_reqs = 0;

  // predictor state: last four columns of rows 0..4, plus the 5x5 view
  longint      win[NR][4];
  longint      grid[NR][5];
  int unsigned cols_seen = 0;

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic longint laplacian(int r, int k);
    longint v;
    v = grid[r][k] * 4 - grid[r-1][k] - grid[r+1][k] - grid[r][k-1] - grid[r][k+1];
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v;
  endfunction

  function automatic bit stencil_step(input column_t col, output flux_t fx);
    longint lc, lw, le, ln, ls;
    fx = '0;
    if (col.row_start) begin
      foreach (win[r, k]) win[r][k] = 0;
      cols_seen = 0;
    end
    for (int r = 0; r < NR; r++) begin
      for (int k = 0; k < 4; k++) grid[r][k] = win[r][k];
      grid[r][4] = longint'($signed(col.smp[r*32 +: 32]));
      for (int k = 0; k < 4; k++) win[r][k] = grid[r][k+1];
    end
    if (cols_seen < 5) cols_seen++;
    if (cols_seen < 5) return 1'b0;
    lc = laplacian(2, 2);
    lw = laplacian(2, 1);
    le = laplacian(2, 3);
    ln = laplacian(1, 2);
    ls = laplacian(3, 2);
    fx.west  = FW'(lc - lw);
    fx.east  = FW'(le - lc);
    fx.north = FW'(lc - ln);
    fx.south = FW'(ls - lc);
    return 1'b1;
  endfunction

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        case ($urandom_range(0, 4))
          0: return SmpMax;
          1: return SmpMin;
          2: return 32'h0;
          3: return 32'hffff_ffff;
          default: return 32'h1;
        endcase
      end
      3, 4, 5, 6: return $urandom;
      default: return 32'($urandom_range(0, 200)) - 32'd100;
    endcase
  endfunction

  task automatic push_col(input bit rs, input logic [DW-1:0] d);
    column_t c;
    c.row_start = rs;
    c.smp = d;
    columns_pending.push_back(c);
  endtask

  // rows of random length with random content; a few short rows and
  // missing row starts mixed in
  task automatic push_rows(input int n_items);
    int left, len, p;
    logic [DW-1:0] d;
    left = n_items;
    while (left > 0) begin
      p = $urandom_range(0, 99);
      if (p < 85) len = $urandom_range(5, 40);
      else if (p < 95) len = $urandom_range(1, 4);
      else len = $urandom_range(60, 120);
      if (len > left) len = left;
      for (int k = 0; k < len; k++) begin
        d = '0;
        for (int r = 0; r < NR; r++) d[r*32 +: 32] = rand_sample();
        push_col(k == 0 && $urandom_range(0, 19) != 0, d);
      end
      left -= len;
    end
  endtask

  task automatic wait_drained();
    while (columns_pending.size() != 0 || s_axis_tvalid || flux_due.size() != 0)
      @(negedge clk_i);
  endtask

  // sender
  column_t nxt_col;
  int      src_gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_gap_left <= 0;
    end else if (s_axis_tvalid && !s_axis_tready) begin
      // hold the current column
    end else if (src_gap_left > 0) begin
      s_axis_tvalid <= 1'b0;
      src_gap_left <= src_gap_left - 1;
    end else if (columns_pending.size() != 0) begin
      nxt_col = columns_pending.pop_front();
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= nxt_col.smp;
      s_axis_tuser <= nxt_col.row_start;
      src_gap_left <= src_gaps_on ? pick_gap() : 0;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // receiver
  int snk_stall_left;
  int hold_left;
  int hold_seen;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      snk_stall_left <= 0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (snk_stall_left > 0) begin
      snk_stall_left <= snk_stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (snk_gaps_on && $urandom_range(0, 3) == 0) begin
      snk_stall_left <= pick_gap();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // check outputs, then predict from the accepted column
  flux_t got_flux, exp_flux, new_flux;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_flux = m_axis_tdata;
      if (flux_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output transfer: %h", got_flux);
      end else begin
        exp_flux = flux_due.pop_front();
        if (got_flux.west != exp_flux.west || got_flux.east != exp_flux.east ||
            got_flux.north != exp_flux.north || got_flux.south != exp_flux.south) begin
          errors++;
          if (errors <= 10)
            $display("flux mismatch: west %h/%h east %h/%h north %h/%h south %h/%h (exp/got)",
                     exp_flux.west, got_flux.west, exp_flux.east, got_flux.east,
                     exp_flux.north, got_flux.north, exp_flux.south, got_flux.south);
        end
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      if (stencil_step('{row_start: s_axis_tuser, smp: s_axis_tdata}, new_flux))
        flux_due.push_back(new_flux);
    end
  end

  initial begin
    #6000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [DW-1:0] d;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // no row start after reset; checkerboard of extremes drives every
    // Laplacian into saturation at both bounds and wraps the fluxes
    for (int k = 0; k < 7; k++) begin
      for (int r = 0; r < NR; r++) d[r*32 +: 32] = ((r + k) % 2 == 1) ? SmpMin : SmpMax;
      push_col(1'b0, d);
    end
    // row of four columns: never fills the window
    for (int k = 0; k < 4; k++) begin
      for (int r = 0; r < NR; r++) d[r*32 +: 32] = (k % 2 == 1) ? 32'hffff_ffff : 32'h0;
      push_col(k == 0, d);
    end
    // fresh row, mixed values around the centre
    for (int k = 0; k < 6; k++) begin
      for (int r = 0; r < NR; r++)
        d[r*32 +: 32] = (r == 2 && k == 2) ? SmpMin : (r == 1 ? SmpMax : 32'(r * 7 - k * 3));
      push_col(k == 0, d);
    end
    wait_drained();

    push_rows(350);
    wait_drained();

    // back to back on both sides
    src_gaps_on = 1'b0;
    snk_gaps_on = 1'b0;
    push_rows(300);
    wait_drained();

    // long receiver hold-off while the sender keeps offering
    hold_reqs++;
    push_rows(120);
    wait_drained();

    src_gaps_on = 1'b1;
    snk_gaps_on = 1'b1;
    push_rows(460);
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (errors == 0 && flux_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
design/hdlf_pkg.sv
design/hdlf_front.sv
design/hdlf_queue.sv
design/hdlf_back.sv
design/hdiff_laplacian_flux.sv
dv/tb.sv
